[rtl/kti_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the keyframe TRS interpolator.
// No dependencies; every other rtl file depends on this package.
package kti_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 7;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;
  localparam int DEF_MAX_KEYS = 64;

  localparam int MUL_W  = VAL_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIVD_W = VAL_W + FRAC_BITS;
  localparam int DIVS_W = VAL_W + 1;
  localparam int QUO_W  = FRAC_BITS + 2;
  localparam int RAD_W  = 2 * VAL_W;
  localparam int ROOT_W = VAL_W;
  localparam int NORM_W = ROOT_W + 1;

  localparam int VEC_WORD_W = 4 * VAL_W;
  localparam int ROT_WORD_W = 5 * VAL_W;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] TRK_POS = 2'd0;
  localparam logic [1:0] TRK_ROT = 2'd1;
  localparam logic [1:0] TRK_SCL = 2'd2;

  localparam logic [1:0] REG_POS_CNT = 2'd0;
  localparam logic [1:0] REG_ROT_CNT = 2'd1;
  localparam logic [1:0] REG_SCL_CNT = 2'd2;

endpackage

[rtl/kti_track_mem.sv]
`timescale 1ns / 1ps
// Key store for one track: one write port, one registered read port.
// Depends on kti_pkg for default sizes.
module kti_track_mem #(
  parameter int DEPTH = kti_pkg::DEF_MAX_KEYS,
  parameter int DW    = kti_pkg::VEC_WORD_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/kti_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on kti_pkg for operand widths.
module kti_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kti_pkg::DIVD_W-1:0] dividend,
  input  logic [kti_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [kti_pkg::QUO_W-1:0]  quotient
);
  import kti_pkg::*;

  localparam int CW = $clog2(QUO_W + 1);

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [QUO_W-1:0]  dvd_lo;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem, dvd_lo[QUO_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= DIVS_W'(dividend[DIVD_W-1:QUO_W]);
      dvd_lo <= dividend[QUO_W-1:0];
      dvs    <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      dvd_lo   <= {dvd_lo[QUO_W-2:0], 1'b0};
      quotient <= {quotient[QUO_W-2:0], ge};
    end
  end

endmodule

[rtl/kti_sqrt.sv]
`timescale 1ns / 1ps
// Integer square root, one root bit per cycle (two radicand bits).
// Depends on kti_pkg for radicand and root widths.
module kti_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kti_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [kti_pkg::ROOT_W-1:0] root
);
  import kti_pkg::*;

  localparam int STEPS = RAD_W / 2;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int RW    = ROOT_W + 2;

  logic [RAD_W-1:0] rad;
  logic [RW-1:0]    rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [RW+1:0]    cur;
  logic [RW+1:0]    trial;
  logic [RW+1:0]    diff;
  logic             ge;

  always_comb begin
    cur   = {rem, rad[RAD_W-1:RAD_W-2]};
    trial = {2'b00, root, 2'b01};
    diff  = cur - trial;
    ge    = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? diff[RW-1:0] : cur[RW-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

[rtl/keyframe_trs_interpolator.sv]
`timescale 1ns / 1ps
// Keyframe TRS interpolator for one joint: position, rotation and scale tracks held in
// on-chip key stores, loaded one key word at a time, and a query word that returns one
// interpolated pose word. A load returns nothing. A query runs on one shared 33x33
// multiplier, a bit-serial divider with a QUO_W = FRAC_BITS+2 bit quotient and a bit-serial
// square root under one sequencer: an interpolated position or scale track takes at most one
// quotient, an interpolated rotation track takes three square roots and up to thirteen
// quotients, and a track with more than one key first searches its keys for the segment.
// The query can wait in its done step on out_stall before the result word is taken. The
// block takes no input word while a query runs.
// Depends on kti_pkg, kti_track_mem, kti_div and kti_sqrt.
module keyframe_trs_interpolator #(
  parameter int MAX_KEYS = kti_pkg::DEF_MAX_KEYS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kti_pkg::PADDR_W-1:0] paddr,
  input  logic [kti_pkg::PDATA_W-1:0] pwdata,
  output logic [kti_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [1:0]                  track,
  input  logic [5:0]                  key_index,
  input  logic [31:0]                 event_time,
  input  logic signed [31:0]          comp_x,
  input  logic signed [31:0]          comp_y,
  input  logic signed [31:0]          comp_z,
  input  logic signed [31:0]          comp_w,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          pos_x,
  output logic signed [31:0]          pos_y,
  output logic signed [31:0]          pos_z,
  output logic signed [31:0]          rot_x,
  output logic signed [31:0]          rot_y,
  output logic signed [31:0]          rot_z,
  output logic signed [31:0]          rot_w,
  output logic signed [31:0]          scale_x,
  output logic signed [31:0]          scale_y,
  output logic signed [31:0]          scale_z,
  output logic                        past_end
);
  import kti_pkg::*;

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int NW  = $clog2(MAX_KEYS + 1);
  localparam int EW  = (NW > CNT_W) ? NW : CNT_W;
  localparam int EW1 = EW + 1;
  localparam int SW  = ((AW > 6) ? AW : 6) + 1;
  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int FW1 = FRAC_BITS + 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_TRK    = 5'd1;
  localparam logic [4:0] S_SRD    = 5'd2;
  localparam logic [4:0] S_SCMP   = 5'd3;
  localparam logic [4:0] S_RDA    = 5'd4;
  localparam logic [4:0] S_CAPA   = 5'd5;
  localparam logic [4:0] S_DECIDE = 5'd6;
  localparam logic [4:0] S_FDIV   = 5'd7;
  localparam logic [4:0] S_LMUL   = 5'd8;
  localparam logic [4:0] S_LRES   = 5'd9;
  localparam logic [4:0] S_RINIT  = 5'd10;
  localparam logic [4:0] S_NSQ    = 5'd11;
  localparam logic [4:0] S_NSQACC = 5'd12;
  localparam logic [4:0] S_NSQS   = 5'd13;
  localparam logic [4:0] S_NSQRT  = 5'd14;
  localparam logic [4:0] S_NCHK   = 5'd15;
  localparam logic [4:0] S_NDIVS  = 5'd16;
  localparam logic [4:0] S_NDIVW  = 5'd17;
  localparam logic [4:0] S_NEND   = 5'd18;
  localparam logic [4:0] S_DOT    = 5'd19;
  localparam logic [4:0] S_DOTACC = 5'd20;
  localparam logic [4:0] S_DOTEND = 5'd21;
  localparam logic [4:0] S_BL1    = 5'd22;
  localparam logic [4:0] S_BL2    = 5'd23;
  localparam logic [4:0] S_BL3    = 5'd24;
  localparam logic [4:0] S_NEXT   = 5'd25;
  localparam logic [4:0] S_DONE   = 5'd26;

  logic [4:0] state;

  // configuration
  logic [CNT_W-1:0] pos_cnt, rot_cnt, scl_cnt;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= CNT_W'(1);
      rot_cnt <= CNT_W'(1);
      scl_cnt <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_POS_CNT: pos_cnt <= pwdata[CNT_W-1:0];
        REG_ROT_CNT: rot_cnt <= pwdata[CNT_W-1:0];
        REG_SCL_CNT: scl_cnt <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POS_CNT: prdata = PDATA_W'(pos_cnt);
      REG_ROT_CNT: prdata = PDATA_W'(rot_cnt);
      REG_SCL_CNT: prdata = PDATA_W'(scl_cnt);
      default:     prdata = '0;
    endcase
  end

  // key stores
  logic              in_acc, load_acc;
  logic [SW-1:0]     slot_ext;
  logic              slot_ok;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [AW-1:0]     idx;
  logic [VEC_WORD_W-1:0] pos_rd, scl_rd;
  logic [ROT_WORD_W-1:0] rot_rd;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && (mode == MODE_LOAD);
  assign slot_ext = SW'(key_index);
  assign slot_ok  = slot_ext < SW'(MAX_KEYS);
  assign wr_addr  = slot_ext[AW-1:0];
  assign rd_addr  = (state == S_SRD) ? idx + AW'(1) : idx;

  kti_track_mem #(.DEPTH(MAX_KEYS), .DW(VEC_WORD_W)) u_pos_mem (
    .clk     (clk),
    .wr_en   (load_acc && slot_ok && (track == TRK_POS)),
    .wr_addr (wr_addr),
    .wr_data ({comp_z, comp_y, comp_x, event_time}),
    .rd_addr (rd_addr),
    .rd_data (pos_rd)
  );

  kti_track_mem #(.DEPTH(MAX_KEYS), .DW(ROT_WORD_W)) u_rot_mem (
    .clk     (clk),
    .wr_en   (load_acc && slot_ok && (track == TRK_ROT)),
    .wr_addr (wr_addr),
    .wr_data ({comp_w, comp_z, comp_y, comp_x, event_time}),
    .rd_addr (rd_addr),
    .rd_data (rot_rd)
  );

  kti_track_mem #(.DEPTH(MAX_KEYS), .DW(VEC_WORD_W)) u_scl_mem (
    .clk     (clk),
    .wr_en   (load_acc && slot_ok && (track == TRK_SCL)),
    .wr_addr (wr_addr),
    .wr_data ({comp_z, comp_y, comp_x, event_time}),
    .rd_addr (rd_addr),
    .rd_data (scl_rd)
  );

  // sequencer registers
  logic [1:0]                tsel;
  logic [1:0]                k;
  logic [1:0]                nsel;
  logic                      interp;
  logic                      dneg;
  logic [EW-1:0]             n;
  logic [VAL_W-1:0]          qt;
  logic [FRAC_BITS-1:0]      f;
  logic [NORM_W-1:0]         norm_n;
  logic [VAL_W-1:0]          key_a_t, key_b_t;
  logic signed [VAL_W-1:0]   key_a_c [4];
  logic signed [VAL_W-1:0]   key_b_c [4];
  logic signed [VAL_W-1:0]   wv [4];
  logic signed [VAL_W-1:0]   qa [4];
  logic signed [VAL_W-1:0]   qb [4];
  logic signed [VAL_W-1:0]   res_pos [3];
  logic signed [VAL_W-1:0]   res_rot [4];
  logic signed [VAL_W-1:0]   res_scl [3];
  logic                      res_past;
  logic signed [PROD_W-1:0]  acc, prod;

  // read word of the current track
  logic [VAL_W-1:0]        rd_time;
  logic signed [VAL_W-1:0] rd_c [4];

  always_comb begin
    unique case (tsel)
      TRK_POS: begin
        rd_time = pos_rd[VAL_W-1:0];
        rd_c[0] = pos_rd[2*VAL_W-1:VAL_W];
        rd_c[1] = pos_rd[3*VAL_W-1:2*VAL_W];
        rd_c[2] = pos_rd[4*VAL_W-1:3*VAL_W];
        rd_c[3] = '0;
      end
      TRK_ROT: begin
        rd_time = rot_rd[VAL_W-1:0];
        rd_c[0] = rot_rd[2*VAL_W-1:VAL_W];
        rd_c[1] = rot_rd[3*VAL_W-1:2*VAL_W];
        rd_c[2] = rot_rd[4*VAL_W-1:3*VAL_W];
        rd_c[3] = rot_rd[5*VAL_W-1:4*VAL_W];
      end
      default: begin
        rd_time = scl_rd[VAL_W-1:0];
        rd_c[0] = scl_rd[2*VAL_W-1:VAL_W];
        rd_c[1] = scl_rd[3*VAL_W-1:2*VAL_W];
        rd_c[2] = scl_rd[4*VAL_W-1:3*VAL_W];
        rd_c[3] = '0;
      end
    endcase
  end

  // effective key count of the current track
  logic [CNT_W-1:0] cnt_sel;
  logic [EW-1:0]    cnt_ext, n_cur;

  always_comb begin
    unique case (tsel)
      TRK_POS: cnt_sel = pos_cnt;
      TRK_ROT: cnt_sel = rot_cnt;
      default: cnt_sel = scl_cnt;
    endcase
    cnt_ext = EW'(cnt_sel);
    if (cnt_ext == '0) begin
      n_cur = EW'(1);
    end else if (cnt_ext > EW'(MAX_KEYS)) begin
      n_cur = EW'(MAX_KEYS);
    end else begin
      n_cur = cnt_ext;
    end
  end

  // shared multiplier
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [VAL_W-1:0] qb_sel;
  logic [FW1-1:0]          one_minus_f;

  assign one_minus_f = {1'b1, {FRAC_BITS{1'b0}}} - FW1'(f);
  assign qb_sel      = dneg ? -qb[k] : qb[k];

  always_comb begin
    unique case (state)
      S_LMUL: begin
        mul_a = MUL_W'(key_b_c[k]) - MUL_W'(key_a_c[k]);
        mul_b = MUL_W'(f);
      end
      S_NSQ: begin
        mul_a = MUL_W'(wv[k]);
        mul_b = MUL_W'(wv[k]);
      end
      S_DOT: begin
        mul_a = MUL_W'(qa[k]);
        mul_b = MUL_W'(qb[k]);
      end
      S_BL1: begin
        mul_a = MUL_W'(qa[k]);
        mul_b = MUL_W'(one_minus_f);
      end
      S_BL2: begin
        mul_a = MUL_W'(qb_sel);
        mul_b = MUL_W'(f);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // rounding: (x + half) >>> FRAC_BITS
  logic signed [PROD_W-1:0] rsrc, rsum, rnd;
  logic [VAL_W-1:0]         rnd_lo;

  always_comb begin
    rsrc   = (state == S_BL3) ? acc + prod : prod;
    rsum   = rsrc + PROD_W'(HALF);
    rnd    = rsum >>> FRAC_BITS;
    rnd_lo = rnd[VAL_W-1:0];
  end

  // divider and square root
  logic                 div_start, div_done;
  logic [DIVD_W-1:0]    div_dvd;
  logic [DIVS_W-1:0]    div_dvs;
  logic [QUO_W-1:0]     div_q;
  logic [VAL_W-1:0]     t_off, seg_len, mag;
  logic                 take_a, before_a;
  logic                 sqrt_start, sqrt_done;
  logic [RAD_W-1:0]     sqrt_rad;
  logic [ROOT_W-1:0]    sqrt_root;
  logic signed [VAL_W-1:0] q_signed;

  assign t_off    = qt - key_a_t;
  assign seg_len  = key_b_t - key_a_t;
  assign take_a   = !interp || (key_b_t <= key_a_t);
  assign before_a = qt < key_a_t;
  assign mag      = wv[k][VAL_W-1] ? ~wv[k] + VAL_W'(1) : wv[k];
  assign q_signed = wv[k][VAL_W-1] ? -signed'(VAL_W'(div_q)) : signed'(VAL_W'(div_q));

  always_comb begin
    div_start = ((state == S_DECIDE) && !take_a && !before_a) || (state == S_NDIVS);
    if (state == S_NDIVS) begin
      div_dvd = (DIVD_W'(mag) << FRAC_BITS) + DIVD_W'(norm_n >> 1);
      div_dvs = DIVS_W'(norm_n);
    end else begin
      div_dvd = DIVD_W'(t_off) << FRAC_BITS;
      div_dvs = DIVS_W'(seg_len);
    end
  end

  assign sqrt_start = (state == S_NSQS);
  assign sqrt_rad   = acc[RAD_W] ? RAD_W'(acc[RAD_W:2]) : acc[RAD_W-1:0];

  kti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  kti_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  logic [4:0] s_interp;
  assign s_interp = (tsel == TRK_ROT) ? S_RINIT : S_LMUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (mode == MODE_QUERY)) begin
            qt       <= event_time;
            tsel     <= TRK_POS;
            res_past <= 1'b0;
            state    <= S_TRK;
          end
        end
        S_TRK: begin
          n   <= n_cur;
          idx <= '0;
          if (n_cur <= EW'(1)) begin
            interp <= 1'b0;
            state  <= S_RDA;
          end else begin
            state <= S_SRD;
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (qt < rd_time) begin
            key_b_t <= rd_time;
            for (int i = 0; i < 4; i++) key_b_c[i] <= rd_c[i];
            interp <= 1'b1;
            state  <= S_RDA;
          end else if (EW1'(idx) + EW1'(2) < EW1'(n)) begin
            idx   <= idx + AW'(1);
            state <= S_SRD;
          end else begin
            res_past <= 1'b1;
            idx      <= AW'(n - EW'(1));
            interp   <= 1'b0;
            state    <= S_RDA;
          end
        end
        S_RDA: state <= S_CAPA;
        S_CAPA: begin
          key_a_t <= rd_time;
          for (int i = 0; i < 4; i++) key_a_c[i] <= rd_c[i];
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          k <= '0;
          if (take_a) begin
            unique case (tsel)
              TRK_POS: for (int i = 0; i < 3; i++) res_pos[i] <= key_a_c[i];
              TRK_ROT: for (int i = 0; i < 4; i++) res_rot[i] <= key_a_c[i];
              default: for (int i = 0; i < 3; i++) res_scl[i] <= key_a_c[i];
            endcase
            state <= S_NEXT;
          end else if (before_a) begin
            f     <= '0;
            state <= s_interp;
          end else begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            f     <= div_q[FRAC_BITS-1:0];
            state <= s_interp;
          end
        end
        S_LMUL: state <= S_LRES;
        S_LRES: begin
          if (tsel == TRK_POS) begin
            res_pos[k] <= key_a_c[k] + signed'(rnd_lo);
          end else begin
            res_scl[k] <= key_a_c[k] + signed'(rnd_lo);
          end
          if (k == 2'd2) begin
            state <= S_NEXT;
          end else begin
            k     <= k + 2'd1;
            state <= S_LMUL;
          end
        end
        S_RINIT: begin
          for (int i = 0; i < 4; i++) wv[i] <= key_a_c[i];
          nsel  <= 2'd0;
          acc   <= '0;
          state <= S_NSQ;
        end
        S_NSQ: state <= S_NSQACC;
        S_NSQACC: begin
          acc <= acc + prod;
          if (k == 2'd3) begin
            state <= S_NSQS;
          end else begin
            k     <= k + 2'd1;
            state <= S_NSQ;
          end
        end
        S_NSQS: state <= S_NSQRT;
        S_NSQRT: begin
          if (sqrt_done) begin
            norm_n <= acc[RAD_W] ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
            state  <= S_NCHK;
          end
        end
        S_NCHK: begin
          k     <= '0;
          state <= (norm_n == '0) ? S_NEND : S_NDIVS;
        end
        S_NDIVS: state <= S_NDIVW;
        S_NDIVW: begin
          if (div_done) begin
            wv[k] <= q_signed;
            if (k == 2'd3) begin
              state <= S_NEND;
            end else begin
              k     <= k + 2'd1;
              state <= S_NDIVS;
            end
          end
        end
        S_NEND: begin
          k   <= '0;
          acc <= '0;
          unique case (nsel)
            2'd0: begin
              for (int i = 0; i < 4; i++) qa[i] <= wv[i];
              for (int i = 0; i < 4; i++) wv[i] <= key_b_c[i];
              nsel  <= 2'd1;
              state <= S_NSQ;
            end
            2'd1: begin
              for (int i = 0; i < 4; i++) qb[i] <= wv[i];
              state <= S_DOT;
            end
            default: begin
              for (int i = 0; i < 4; i++) res_rot[i] <= wv[i];
              state <= S_NEXT;
            end
          endcase
        end
        S_DOT: state <= S_DOTACC;
        S_DOTACC: begin
          acc <= acc + prod;
          if (k == 2'd3) begin
            state <= S_DOTEND;
          end else begin
            k     <= k + 2'd1;
            state <= S_DOT;
          end
        end
        S_DOTEND: begin
          dneg  <= acc[PROD_W-1];
          k     <= '0;
          state <= S_BL1;
        end
        S_BL1: state <= S_BL2;
        S_BL2: begin
          acc   <= prod;
          state <= S_BL3;
        end
        S_BL3: begin
          wv[k] <= signed'(rnd_lo);
          if (k == 2'd3) begin
            k     <= '0;
            acc   <= '0;
            nsel  <= 2'd2;
            state <= S_NSQ;
          end else begin
            k     <= k + 2'd1;
            state <= S_BL1;
          end
        end
        S_NEXT: begin
          if (tsel == TRK_SCL) begin
            state <= S_DONE;
          end else begin
            tsel  <= tsel + 2'd1;
            state <= S_TRK;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            pos_x     <= res_pos[0];
            pos_y     <= res_pos[1];
            pos_z     <= res_pos[2];
            rot_x     <= res_rot[0];
            rot_y     <= res_rot[1];
            rot_z     <= res_rot[2];
            rot_w     <= res_rot[3];
            scale_x   <= res_scl[0];
            scale_y   <= res_scl[1];
            scale_z   <= res_scl[2];
            past_end  <= res_past;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word raised outside the done step");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == MODE_QUERY) |=> state == S_TRK)
    else $error("accepted query did not start a track pass");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == MODE_LOAD) |=> state == S_IDLE)
    else $error("key load left the sequencer busy");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_NDIVS |-> norm_n != '0)
    else $error("normalize divide started with zero norm");
`endif

endmodule
